// File: src/iirdf1_pkg.sv
`timescale 1ns / 1ps

package iirdf1_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int COEFF_W      = 16;
   localparam int DIGIT_W      = 4;
   localparam int DIGITS       = COEFF_W / DIGIT_W;
   localparam int DIGIT_SEL_W  = $clog2(DIGITS);
   localparam int FWD_TAPS     = 8;
   localparam int FB_TAPS      = 8;
   localparam int NUM_TAPS     = FWD_TAPS + FB_TAPS - 1;
   localparam int LINE_W       = NUM_TAPS * COEFF_W;
   localparam int TAP_CNT_W    = 4;
   localparam int CSR_W        = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int COEFFS_PER_CSR = CSR_W / COEFF_W;
   localparam int OPND_W       = SAMPLE_W + 1;
   localparam int PROD_W       = OPND_W + DIGIT_W + 1;
   localparam int PART_W       = OPND_W + COEFF_W;
   localparam int ACC_W        = PART_W + $clog2(NUM_TAPS);
   localparam int ROUND_SHIFT  = 14;
   localparam int ROUND_BIAS   = 1 << (ROUND_SHIFT - 1);
   localparam int SHIFT_W      = ACC_W - ROUND_SHIFT;
   localparam int SAT_MAX      = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAT_MIN      = -(1 << (SAMPLE_W - 1));
   localparam int TOTAL_STEPS  = NUM_TAPS * DIGITS;
   localparam int FB_START     = FWD_TAPS * DIGITS;
   localparam int STEP_CNT_W   = $clog2(TOTAL_STEPS);

   localparam logic [CSR_W-1:0] FWD_LOW_RESET = CSR_W'(1 << ROUND_SHIFT);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FORWARD_TAPS      = 3'd0,
      CSR_FEEDBACK_TAPS     = 3'd1,
      CSR_FORWARD_COEFF_LO  = 3'd2,
      CSR_FORWARD_COEFF_HI  = 3'd3,
      CSR_FEEDBACK_COEFF_LO = 3'd4,
      CSR_FEEDBACK_COEFF_HI = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic step;
      logic first_digit;
      logic last_digit;
      logic feedback;
      logic push_out;
   } ctrl_type;

   function automatic logic [TAP_CNT_W-1:0] clamp_taps(input logic [TAP_CNT_W-1:0] t,
                                                      input logic [TAP_CNT_W-1:0] maxv);
      logic [TAP_CNT_W-1:0] r;
      if (t == '0) begin
         r = TAP_CNT_W'(1);
      end else if (t > maxv) begin
         r = maxv;
      end else begin
         r = t;
      end
      return r;
   endfunction

endpackage

// File: src/iirdf1_coeff_line.sv
`timescale 1ns / 1ps

module iirdf1_coeff_line (
   input  logic                                   clock,
   input  iirdf1_pkg::ctrl_type                   ctrl,
   input  logic [iirdf1_pkg::TAP_CNT_W-1:0]       fwd_count,
   input  logic [iirdf1_pkg::TAP_CNT_W-1:0]       fb_count,
   input  logic [iirdf1_pkg::CSR_W-1:0]           fwd_lo,
   input  logic [iirdf1_pkg::CSR_W-1:0]           fwd_hi,
   input  logic [iirdf1_pkg::CSR_W-1:0]           fb_lo,
   input  logic [iirdf1_pkg::CSR_W-1:0]           fb_hi,
   output logic [iirdf1_pkg::DIGIT_W-1:0]         digit
);
   import iirdf1_pkg::*;

   logic [LINE_W-1:0] line_ff;
   logic [LINE_W-1:0] line_in;
   logic [LINE_W-1:0] load_line;

   // tap order from the top: b0..b7, then a1..a7; unused taps load as zero
   always_comb begin
      load_line = '0;
      for (int t = 0; t < FWD_TAPS; t++) begin
         if (TAP_CNT_W'(t) < fwd_count) begin
            if (t < COEFFS_PER_CSR) begin
               load_line[LINE_W-1-COEFF_W*t -: COEFF_W] = fwd_lo[COEFF_W*t +: COEFF_W];
            end else begin
               load_line[LINE_W-1-COEFF_W*t -: COEFF_W] =
                  fwd_hi[COEFF_W*(t-COEFFS_PER_CSR) +: COEFF_W];
            end
         end
      end
      for (int j = 1; j < FB_TAPS; j++) begin
         if (TAP_CNT_W'(j) < fb_count) begin
            if (j < COEFFS_PER_CSR) begin
               load_line[LINE_W-1-COEFF_W*(FWD_TAPS+j-1) -: COEFF_W] =
                  fb_lo[COEFF_W*j +: COEFF_W];
            end else begin
               load_line[LINE_W-1-COEFF_W*(FWD_TAPS+j-1) -: COEFF_W] =
                  fb_hi[COEFF_W*(j-COEFFS_PER_CSR) +: COEFF_W];
            end
         end
      end
   end

   always_comb begin
      line_in = line_ff;
      if (ctrl.load) begin
         line_in = load_line;
      end else if (ctrl.step) begin
         line_in = {line_ff[LINE_W-DIGIT_W-1:0], DIGIT_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

   assign digit = line_ff[LINE_W-1 -: DIGIT_W];

endmodule

// File: src/iirdf1_history.sv
`timescale 1ns / 1ps

module iirdf1_history (
   input  logic                                   clock,
   input  logic                                   reset,
   input  iirdf1_pkg::ctrl_type                   ctrl,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] result,
   output logic signed [iirdf1_pkg::OPND_W-1:0]   operand
);
   import iirdf1_pkg::*;

   // fwd ring: slots 0..FWD_TAPS-2 hold the input history between transactions
   logic [SAMPLE_W-1:0] fwd_ff [FWD_TAPS];
   logic [SAMPLE_W-1:0] fwd_in [FWD_TAPS];
   logic [SAMPLE_W-1:0] fb_ff  [FB_TAPS-1];
   logic [SAMPLE_W-1:0] fb_in  [FB_TAPS-1];

   always_comb begin
      fwd_in = fwd_ff;
      if (ctrl.load) begin
         fwd_in[0] = sample;
         for (int k = 1; k < FWD_TAPS; k++) begin
            fwd_in[k] = fwd_ff[k-1];
         end
      end else if (ctrl.step && ctrl.last_digit && !ctrl.feedback) begin
         for (int k = 0; k < FWD_TAPS - 1; k++) begin
            fwd_in[k] = fwd_ff[k+1];
         end
         fwd_in[FWD_TAPS-1] = fwd_ff[0];
      end
   end

   always_comb begin
      fb_in = fb_ff;
      if (ctrl.push_out) begin
         fb_in[0] = result;
         for (int k = 1; k < FB_TAPS - 1; k++) begin
            fb_in[k] = fb_ff[k-1];
         end
      end else if (ctrl.step && ctrl.last_digit && ctrl.feedback) begin
         for (int k = 0; k < FB_TAPS - 2; k++) begin
            fb_in[k] = fb_ff[k+1];
         end
         fb_in[FB_TAPS-2] = fb_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FWD_TAPS; k++) begin
            fwd_ff[k] <= '0;
         end
         for (int k = 0; k < FB_TAPS - 1; k++) begin
            fb_ff[k] <= '0;
         end
      end else begin
         fwd_ff <= fwd_in;
         fb_ff  <= fb_in;
      end
   end

   // feedback taps subtract: negate the sample, not the coefficient
   always_comb begin
      if (ctrl.feedback) begin
         operand = -OPND_W'(signed'(fb_ff[0]));
      end else begin
         operand = OPND_W'(signed'(fwd_ff[0]));
      end
   end

endmodule

// File: src/iirdf1_mac.sv
`timescale 1ns / 1ps

module iirdf1_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  iirdf1_pkg::ctrl_type                   ctrl,
   input  logic signed [iirdf1_pkg::OPND_W-1:0]   operand,
   input  logic [iirdf1_pkg::DIGIT_W-1:0]         digit,
   output logic signed [iirdf1_pkg::SAMPLE_W-1:0] filtered,
   output logic                                   clipped
);
   import iirdf1_pkg::*;

   logic signed [DIGIT_W:0]      digit_ext;
   logic signed [PROD_W-1:0]     prod;
   logic signed [PART_W-1:0]     part_ff;
   logic signed [PART_W-1:0]     part_in;
   logic                         pend_ff;
   logic                         pend_in;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic signed [ACC_W-1:0]      biased;
   logic signed [SHIFT_W-1:0]    shifted;

   // most significant digit carries the coefficient sign
   assign digit_ext = ctrl.first_digit ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
   assign prod      = PROD_W'(operand) * PROD_W'(digit_ext);

   always_comb begin
      part_in = part_ff;
      if (ctrl.step) begin
         part_in = (ctrl.first_digit ? PART_W'(0) : (part_ff <<< DIGIT_W)) + PART_W'(prod);
      end
   end

   assign pend_in = ctrl.step && ctrl.last_digit;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = '0;
      end else if (pend_ff) begin
         acc_in = acc_ff + ACC_W'(part_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      acc_ff  <= acc_in;
   end

   assign biased  = acc_ff + ACC_W'(ROUND_BIAS);
   assign shifted = biased[ACC_W-1:ROUND_SHIFT];

   always_comb begin
      if (shifted > SHIFT_W'(SAT_MAX)) begin
         filtered = SAMPLE_W'(SAT_MAX);
         clipped  = 1'b1;
      end else if (shifted < SHIFT_W'(SAT_MIN)) begin
         filtered = SAMPLE_W'(SAT_MIN);
         clipped  = 1'b1;
      end else begin
         filtered = shifted[SAMPLE_W-1:0];
         clipped  = 1'b0;
      end
   end

endmodule

// File: src/iir_filter_direct_form_one_unit.sv
`timescale 1ns / 1ps

// Direct form I IIR filter, Q1.15 samples, Q2.14 coefficients, one result per
// sample. A transaction passes through an idle/accept state, the digit steps,
// an accumulate and a round/saturate state; the steps come from the single
// 17x4-bit digit multiplier, which walks four coefficient digits for each of
// the fifteen taps (eight feedforward, seven feedback), with unused taps run
// as zero. The result sits in an output register, so the next sample is taken
// while it waits; the user must write config only while idle (not enforced).
module iir_filter_direct_form_one_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [iirdf1_pkg::SAMPLE_W-1:0]   rsp_filtered,
   output logic                                     rsp_clipped,
   input  logic                                     csr_we,
   input  logic [iirdf1_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [iirdf1_pkg::CSR_W-1:0]             csr_wdata
);
   import iirdf1_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_ROUND = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [STEP_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TAP_CNT_W-1:0]     fwd_taps_ff, fb_taps_ff;
   logic [CSR_W-1:0]         fwd_lo_ff, fwd_hi_ff, fb_lo_ff, fb_hi_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic                     rsp_clipped_ff;
   ctrl_type                 ctrl;
   logic [DIGIT_W-1:0]       digit;
   logic signed [OPND_W-1:0] operand;
   logic signed [SAMPLE_W-1:0] mac_filtered;
   logic                     mac_clipped;
   logic                     req_fire;
   logic                     out_free;
   logic [TAP_CNT_W-1:0]     fwd_count, fb_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_taps_ff <= TAP_CNT_W'(1);
         fb_taps_ff  <= TAP_CNT_W'(1);
         fwd_lo_ff   <= FWD_LOW_RESET;
         fwd_hi_ff   <= '0;
         fb_lo_ff    <= '0;
         fb_hi_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FORWARD_TAPS:      fwd_taps_ff <= csr_wdata[TAP_CNT_W-1:0];
            CSR_FEEDBACK_TAPS:     fb_taps_ff  <= csr_wdata[TAP_CNT_W-1:0];
            CSR_FORWARD_COEFF_LO:  fwd_lo_ff   <= csr_wdata;
            CSR_FORWARD_COEFF_HI:  fwd_hi_ff   <= csr_wdata;
            CSR_FEEDBACK_COEFF_LO: fb_lo_ff    <= csr_wdata;
            CSR_FEEDBACK_COEFF_HI: fb_hi_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign fwd_count = clamp_taps(fwd_taps_ff, TAP_CNT_W'(FWD_TAPS));
   assign fb_count  = clamp_taps(fb_taps_ff, TAP_CNT_W'(FB_TAPS));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ctrl             = '0;
      ctrl.load        = req_fire;
      ctrl.step        = (state_ff == ST_MAC);
      ctrl.first_digit = (cnt_ff[DIGIT_SEL_W-1:0] == '0);
      ctrl.last_digit  = (cnt_ff[DIGIT_SEL_W-1:0] == DIGIT_SEL_W'(DIGITS - 1));
      ctrl.feedback    = (cnt_ff >= STEP_CNT_W'(FB_START));
      ctrl.push_out    = (state_ff == ST_ROUND) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_fire) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + STEP_CNT_W'(1);
            if (cnt_ff == STEP_CNT_W'(TOTAL_STEPS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.push_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push_out) begin
         rsp_filtered_ff <= mac_filtered;
         rsp_clipped_ff  <= mac_clipped;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_clipped  = rsp_clipped_ff;

   iirdf1_coeff_line u_coeff_line (
      .clock     (clock),
      .ctrl      (ctrl),
      .fwd_count (fwd_count),
      .fb_count  (fb_count),
      .fwd_lo    (fwd_lo_ff),
      .fwd_hi    (fwd_hi_ff),
      .fb_lo     (fb_lo_ff),
      .fb_hi     (fb_hi_ff),
      .digit     (digit)
   );

   iirdf1_history u_history (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .sample  (req_sample),
      .result  (mac_filtered),
      .operand (operand)
   );

   iirdf1_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .operand  (operand),
      .digit    (digit),
      .filtered (mac_filtered),
      .clipped  (mac_clipped)
   );

endmodule

// File: src/iirdf1_checker.sv
`timescale 1ns / 1ps

module iirdf1_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]   rsp_filtered,
   input  logic                                     rsp_clipped
);
   import iirdf1_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered) && $stable(rsp_clipped))
      else $error("result changed while stalled");

   // clipping only ever reports a rail value
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_filtered == SAMPLE_W'(SAT_MAX) || rsp_filtered == SAMPLE_W'(SAT_MIN))
      else $error("clipped flag without saturated value");

   // one transaction in flight: input closes after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted twice in a row");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind iir_filter_direct_form_one_unit iirdf1_checker u_iirdf1_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_filtered (rsp_filtered),
   .rsp_clipped  (rsp_clipped)
);
